@@ hdl/ffha_pkg.sv @@
// Shared constants, types and codes for the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_BYTES   = 65536;
  localparam int HEADER_BYTES = 48;
  localparam int ALIGN_BYTES  = 16;
  localparam int ALIGN_SH     = $clog2(ALIGN_BYTES);
  localparam int NBLK         = HEAP_BYTES / ALIGN_BYTES;
  localparam int ADR_W        = $clog2(NBLK);
  localparam int IDX_W        = ADR_W + 1;
  localparam int SIZE_W       = 17;
  localparam int REQ_W        = 24;
  localparam int NEED_W       = REQ_W + 1;
  localparam int PTR_W        = 16;
  localparam int SPLIT_MIN    = HEADER_BYTES + 16;

  localparam logic [IDX_W-1:0]  NIL       = IDX_W'(NBLK);
  localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(HEAP_BYTES - HEADER_BYTES);

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_FREE = 2'd1,
    KIND_USED = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    RES_OK     = 2'd0,
    RES_NULL   = 2'd1,
    RES_NOMEM  = 2'd2,
    RES_BADPTR = 2'd3
  } res_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLR, OP_INIT, OP_ACCEPT, OP_A_CHK, OP_A_RD, OP_S1, OP_S2,
    OP_U1, OP_U2, OP_F_CHK, OP_P1, OP_P2, OP_RD_R, OP_RRD, OP_M1, OP_M2,
    OP_RD_L, OP_LRD, OP_BRD
  } op_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_INIT, ST_IDLE, ST_A_CHK, ST_A_RD, ST_S1, ST_S2, ST_U1, ST_U2,
    ST_F_CHK, ST_P1, ST_P2, ST_RD_R, ST_RRD, ST_M1, ST_M2, ST_RD_L, ST_LRD,
    ST_BRD, ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    CTX_ALLOC = 2'd0,
    CTX_RIGHT = 2'd1,
    CTX_LEFT  = 2'd2
  } ctx_t;

  typedef struct packed {
    op_t  op;
    logic in_ready;
    logic mark_used;
    logic out_load;
    res_t code;
    logic addr_en;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_fire;
    logic req_free;
    logic size_zero;
    logic null_ptr;
    logic bad_ptr;
    logic b_nil;
    logic kind_free;
    logic kind_used;
    logic fits;
    logic big;
    logic r_ovf;
    logic r_nil;
    logic l_nil;
    logic out_free;
  } stat_t;

endpackage

@@ hdl/ffha_if.sv @@
// Request and result channel interfaces.
interface ffha_in_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [ffha_pkg::REQ_W-1:0]   alloc_size;
  logic [ffha_pkg::PTR_W-1:0]   free_addr;
  modport source (output valid, req_type, alloc_size, free_addr, input ready);
  modport sink   (input valid, req_type, alloc_size, free_addr, output ready);
endinterface

interface ffha_out_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   status;
  logic [ffha_pkg::PTR_W-1:0]   result_addr;
  modport source (output valid, status, result_addr, input ready);
  modport sink   (input valid, status, result_addr, output ready);
endinterface

@@ hdl/first_fit_heap_allocator.sv @@
// First-fit heap allocator top level: sequencer, datapath and checks.
//
// Manages a 64 KiB arena as blocks of a 48-byte header plus payload, with
// freed and split blocks pushed at the front of a doubly linked free list.
// After reset a clearing pass sweeps the block kind table and sets up the
// single initial free block; no request is taken meanwhile. One request is
// handled at a time, each step using block tables that have one read port,
// one write port and registered reads. An allocate passes through accept and
// result, a check and a read per free list entry walked, then a split when
// the block is big enough, and an unlink. A free ends early on a misaligned
// pointer and runs longest when it merges with both neighbors. A new request
// is taken once the previous result has been loaded into the output register.
module first_fit_heap_allocator (
  input  logic       clk,
  input  logic       rst_n,
  ffha_in_if.sink    in_ch,
  ffha_out_if.source out_ch
);

  ffha_pkg::cmd_t  cmd;
  ffha_pkg::stat_t stat;

  ffha_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .cmd   (cmd)
  );

  ffha_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while a transfer is in progress");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ffha_pkg::RES_OK) |-> out_ch.result_addr == '0)
    else $error("nonzero address on failed request");

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten");
`endif

endmodule

@@ hdl/ffha_ctrl.sv @@
// Allocator sequencer: walks alloc and free operations step by step.
module ffha_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  ffha_pkg::stat_t stat,
  output ffha_pkg::cmd_t  cmd
);

  ffha_pkg::state_t state_r, state_nxt;
  ffha_pkg::ctx_t   ctx_r, ctx_nxt;
  ffha_pkg::res_t   code_r, code_nxt;
  logic             aen_r, aen_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffha_pkg::ST_CLR;
      ctx_r   <= ffha_pkg::CTX_ALLOC;
      code_r  <= ffha_pkg::RES_OK;
      aen_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ctx_r   <= ctx_nxt;
      code_r  <= code_nxt;
      aen_r   <= aen_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    ctx_nxt       = ctx_r;
    code_nxt      = code_r;
    aen_nxt       = aen_r;
    cmd.op        = ffha_pkg::OP_NONE;
    cmd.in_ready  = 1'b0;
    cmd.mark_used = 1'b0;
    cmd.out_load  = 1'b0;
    cmd.code      = code_r;
    cmd.addr_en   = aen_r;
    unique case (state_r)
      ffha_pkg::ST_CLR: begin
        cmd.op = ffha_pkg::OP_CLR;
        if (stat.clr_last) state_nxt = ffha_pkg::ST_INIT;
      end
      ffha_pkg::ST_INIT: begin
        cmd.op    = ffha_pkg::OP_INIT;
        state_nxt = ffha_pkg::ST_IDLE;
      end
      ffha_pkg::ST_IDLE: begin
        cmd.in_ready = 1'b1;
        aen_nxt      = 1'b0;
        if (stat.in_fire) begin
          cmd.op = ffha_pkg::OP_ACCEPT;
          priority if (!stat.req_free && stat.size_zero) begin
            code_nxt  = ffha_pkg::RES_NULL;
            state_nxt = ffha_pkg::ST_OUT;
          end else if (!stat.req_free) begin
            ctx_nxt   = ffha_pkg::CTX_ALLOC;
            state_nxt = ffha_pkg::ST_A_CHK;
          end else if (stat.null_ptr) begin
            code_nxt  = ffha_pkg::RES_NULL;
            state_nxt = ffha_pkg::ST_OUT;
          end else if (stat.bad_ptr) begin
            code_nxt  = ffha_pkg::RES_BADPTR;
            state_nxt = ffha_pkg::ST_OUT;
          end else begin
            state_nxt = ffha_pkg::ST_F_CHK;
          end
        end
      end
      ffha_pkg::ST_A_CHK: begin
        cmd.op = ffha_pkg::OP_A_CHK;
        if (stat.b_nil) begin
          code_nxt  = ffha_pkg::RES_NOMEM;
          state_nxt = ffha_pkg::ST_OUT;
        end else begin
          state_nxt = ffha_pkg::ST_A_RD;
        end
      end
      ffha_pkg::ST_A_RD: begin
        cmd.op = ffha_pkg::OP_A_RD;
        priority if (!stat.kind_free || (stat.fits && stat.big && stat.r_ovf)) begin
          code_nxt  = ffha_pkg::RES_NOMEM;
          state_nxt = ffha_pkg::ST_OUT;
        end else if (stat.fits && stat.big) begin
          state_nxt = ffha_pkg::ST_S1;
        end else if (stat.fits) begin
          state_nxt = ffha_pkg::ST_U1;
        end else begin
          state_nxt = ffha_pkg::ST_A_CHK;
        end
      end
      ffha_pkg::ST_S1: begin
        cmd.op    = ffha_pkg::OP_S1;
        state_nxt = ffha_pkg::ST_S2;
      end
      ffha_pkg::ST_S2: begin
        cmd.op    = ffha_pkg::OP_S2;
        state_nxt = ffha_pkg::ST_U1;
      end
      ffha_pkg::ST_U1: begin
        cmd.op    = ffha_pkg::OP_U1;
        state_nxt = ffha_pkg::ST_U2;
      end
      ffha_pkg::ST_U2: begin
        cmd.op = ffha_pkg::OP_U2;
        if (ctx_r == ffha_pkg::CTX_ALLOC) begin
          cmd.mark_used = 1'b1;
          code_nxt      = ffha_pkg::RES_OK;
          aen_nxt       = 1'b1;
          state_nxt     = ffha_pkg::ST_OUT;
        end else begin
          state_nxt = ffha_pkg::ST_M1;
        end
      end
      ffha_pkg::ST_F_CHK: begin
        cmd.op = ffha_pkg::OP_F_CHK;
        if (!stat.kind_used) begin
          code_nxt  = ffha_pkg::RES_BADPTR;
          state_nxt = ffha_pkg::ST_OUT;
        end else begin
          state_nxt = ffha_pkg::ST_P1;
        end
      end
      ffha_pkg::ST_P1: begin
        cmd.op    = ffha_pkg::OP_P1;
        state_nxt = ffha_pkg::ST_P2;
      end
      ffha_pkg::ST_P2: begin
        cmd.op    = ffha_pkg::OP_P2;
        state_nxt = ffha_pkg::ST_RD_R;
      end
      ffha_pkg::ST_RD_R: begin
        cmd.op    = ffha_pkg::OP_RD_R;
        state_nxt = stat.r_nil ? ffha_pkg::ST_RD_L : ffha_pkg::ST_RRD;
      end
      ffha_pkg::ST_RRD: begin
        cmd.op = ffha_pkg::OP_RRD;
        if (stat.kind_free) begin
          ctx_nxt   = ffha_pkg::CTX_RIGHT;
          state_nxt = ffha_pkg::ST_U1;
        end else begin
          state_nxt = ffha_pkg::ST_RD_L;
        end
      end
      ffha_pkg::ST_RD_L: begin
        cmd.op = ffha_pkg::OP_RD_L;
        if (stat.l_nil) begin
          code_nxt  = ffha_pkg::RES_OK;
          state_nxt = ffha_pkg::ST_OUT;
        end else begin
          state_nxt = ffha_pkg::ST_LRD;
        end
      end
      ffha_pkg::ST_LRD: begin
        cmd.op = ffha_pkg::OP_LRD;
        if (stat.kind_free) begin
          state_nxt = ffha_pkg::ST_BRD;
        end else begin
          code_nxt  = ffha_pkg::RES_OK;
          state_nxt = ffha_pkg::ST_OUT;
        end
      end
      ffha_pkg::ST_BRD: begin
        cmd.op    = ffha_pkg::OP_BRD;
        ctx_nxt   = ffha_pkg::CTX_LEFT;
        state_nxt = ffha_pkg::ST_U1;
      end
      ffha_pkg::ST_M1: begin
        cmd.op    = ffha_pkg::OP_M1;
        state_nxt = ffha_pkg::ST_M2;
      end
      ffha_pkg::ST_M2: begin
        cmd.op = ffha_pkg::OP_M2;
        if (ctx_r == ffha_pkg::CTX_RIGHT) begin
          state_nxt = ffha_pkg::ST_RD_L;
        end else begin
          code_nxt  = ffha_pkg::RES_OK;
          state_nxt = ffha_pkg::ST_OUT;
        end
      end
      ffha_pkg::ST_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ffha_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ffha_pkg::ST_CLR;
    endcase
  end

endmodule

@@ hdl/ffha_dp.sv @@
// Allocator datapath: block tables, working registers and result register.
module ffha_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  ffha_pkg::cmd_t  cmd,
  output ffha_pkg::stat_t stat,
  ffha_in_if.sink         in_ch,
  ffha_out_if.source      out_ch
);

  localparam int IW = ffha_pkg::IDX_W;
  localparam int AW = ffha_pkg::ADR_W;
  localparam int SW = ffha_pkg::SIZE_W;
  localparam int NW = ffha_pkg::NEED_W;
  localparam int PW = ffha_pkg::PTR_W;

  // block tables
  ffha_pkg::kind_t kind_mem [ffha_pkg::NBLK];
  logic [SW-1:0]   size_mem [ffha_pkg::NBLK];
  logic [IW-1:0]   pp_mem   [ffha_pkg::NBLK];
  logic [IW-1:0]   pn_mem   [ffha_pkg::NBLK];
  logic [IW-1:0]   fp_mem   [ffha_pkg::NBLK];
  logic [IW-1:0]   fn_mem   [ffha_pkg::NBLK];

  ffha_pkg::kind_t kind_rd_r;
  logic [SW-1:0]   size_rd_r;
  logic [IW-1:0]   pp_rd_r, pn_rd_r, fp_rd_r, fn_rd_r;

  logic [AW-1:0]   ra;
  logic            kind_we, size_we, pp_we, pn_we, fp_we, fn_we;
  logic [AW-1:0]   kind_wa, size_wa, pp_wa, pn_wa, fp_wa, fn_wa;
  ffha_pkg::kind_t kind_wd;
  logic [SW-1:0]   size_wd;
  logic [IW-1:0]   pp_wd, pn_wd, fp_wd, fn_wd;

  // working registers
  logic [AW-1:0]   clr_cnt_r;
  logic [IW-1:0]   head_r;
  logic [NW-1:0]   need_r;
  logic [IW-1:0]   b_r, r_r, l_r, t_r, d_r, s_r, nx_r, cn_r, p_r, n_r;
  logic [SW-1:0]   left_r, szb_r, dsz_r, ssz_r;
  logic [PW-1:0]   res_addr_r;
  logic            out_valid_r;
  logic [1:0]      out_status_r;
  logic [PW-1:0]   out_addr_r;

  // request decode
  logic            in_fire;
  logic [NW-1:0]   need_c;
  logic [PW-1:0]   off_c;
  logic [AW-1:0]   idx_c;
  logic [SW-1:0]   left_c;
  logic [IW:0]     rcalc_c;
  logic [SW-1:0]   msum_c;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign in_ch.ready = cmd.in_ready;
  assign need_c   = ({1'b0, in_ch.alloc_size} + NW'(ffha_pkg::ALIGN_BYTES - 1))
                    & ~NW'(ffha_pkg::ALIGN_BYTES - 1);
  assign off_c    = in_ch.free_addr - PW'(ffha_pkg::HEADER_BYTES);
  assign idx_c    = off_c[AW+ffha_pkg::ALIGN_SH-1:ffha_pkg::ALIGN_SH];
  assign left_c   = size_rd_r - need_r[SW-1:0];
  assign rcalc_c  = {1'b0, b_r}
                    + (IW+1)'((need_r + NW'(ffha_pkg::HEADER_BYTES)) >> ffha_pkg::ALIGN_SH);
  assign msum_c   = dsz_r + SW'(ffha_pkg::HEADER_BYTES) + ssz_r;

  always_comb begin
    stat.clr_last  = &clr_cnt_r;
    stat.in_fire   = in_fire;
    stat.req_free  = in_ch.req_type;
    stat.size_zero = (in_ch.alloc_size == '0);
    stat.null_ptr  = (in_ch.free_addr == '0);
    stat.bad_ptr   = (in_ch.free_addr < PW'(ffha_pkg::HEADER_BYTES))
                     || (off_c[ffha_pkg::ALIGN_SH-1:0] != '0);
    stat.b_nil     = b_r[IW-1];
    stat.kind_free = (kind_rd_r == ffha_pkg::KIND_FREE);
    stat.kind_used = (kind_rd_r == ffha_pkg::KIND_USED);
    stat.fits      = ({{(NW-SW){1'b0}}, size_rd_r} >= need_r);
    stat.big       = (left_c > SW'(ffha_pkg::SPLIT_MIN));
    stat.r_ovf     = (rcalc_c >= (IW+1)'(ffha_pkg::NBLK));
    stat.r_nil     = r_r[IW-1];
    stat.l_nil     = l_r[IW-1];
    stat.out_free  = !out_valid_r || out_ch.ready;
  end

  // read address and write ports
  always_comb begin
    ra      = b_r[AW-1:0];
    kind_we = 1'b0; kind_wa = t_r[AW-1:0]; kind_wd = ffha_pkg::KIND_NONE;
    size_we = 1'b0; size_wa = t_r[AW-1:0]; size_wd = need_r[SW-1:0];
    pp_we   = 1'b0; pp_wa   = nx_r[AW-1:0]; pp_wd  = ffha_pkg::NIL;
    pn_we   = 1'b0; pn_wa   = t_r[AW-1:0]; pn_wd   = ffha_pkg::NIL;
    fp_we   = 1'b0; fp_wa   = t_r[AW-1:0]; fp_wd   = ffha_pkg::NIL;
    fn_we   = 1'b0; fn_wa   = t_r[AW-1:0]; fn_wd   = ffha_pkg::NIL;
    unique case (cmd.op)
      ffha_pkg::OP_CLR: begin
        kind_we = 1'b1; kind_wa = clr_cnt_r;
      end
      ffha_pkg::OP_INIT: begin
        kind_we = 1'b1; kind_wa = '0; kind_wd = ffha_pkg::KIND_FREE;
        size_we = 1'b1; size_wa = '0; size_wd = ffha_pkg::INIT_SIZE;
        pp_we   = 1'b1; pp_wa   = '0;
        pn_we   = 1'b1; pn_wa   = '0;
        fp_we   = 1'b1; fp_wa   = '0;
        fn_we   = 1'b1; fn_wa   = '0;
      end
      ffha_pkg::OP_ACCEPT: ra = idx_c;
      ffha_pkg::OP_S1: begin
        kind_we = 1'b1; kind_wa = r_r[AW-1:0]; kind_wd = ffha_pkg::KIND_FREE;
        size_we = 1'b1; size_wa = r_r[AW-1:0];
        size_wd = left_r - SW'(ffha_pkg::HEADER_BYTES);
        pp_we   = 1'b1; pp_wa   = r_r[AW-1:0]; pp_wd = t_r;
        pn_we   = 1'b1; pn_wa   = r_r[AW-1:0]; pn_wd = nx_r;
        fp_we   = 1'b1; fp_wa   = r_r[AW-1:0];
        fn_we   = 1'b1; fn_wa   = r_r[AW-1:0]; fn_wd = head_r;
      end
      ffha_pkg::OP_S2: begin
        size_we = 1'b1;
        pn_we   = 1'b1; pn_wd = r_r;
        pp_we   = !nx_r[IW-1]; pp_wd = r_r;
        fp_we   = !head_r[IW-1]; fp_wa = head_r[AW-1:0]; fp_wd = r_r;
      end
      ffha_pkg::OP_U1: begin
        fn_we = !p_r[IW-1]; fn_wa = p_r[AW-1:0]; fn_wd = n_r;
        fp_we = !n_r[IW-1]; fp_wa = n_r[AW-1:0]; fp_wd = p_r;
      end
      ffha_pkg::OP_U2: begin
        fp_we   = 1'b1;
        fn_we   = 1'b1;
        kind_we = cmd.mark_used; kind_wd = ffha_pkg::KIND_USED;
      end
      ffha_pkg::OP_P1: begin
        kind_we = 1'b1; kind_wa = b_r[AW-1:0]; kind_wd = ffha_pkg::KIND_FREE;
        fp_we   = 1'b1; fp_wa   = b_r[AW-1:0];
        fn_we   = 1'b1; fn_wa   = b_r[AW-1:0]; fn_wd = head_r;
      end
      ffha_pkg::OP_P2: begin
        fp_we = !head_r[IW-1]; fp_wa = head_r[AW-1:0]; fp_wd = b_r;
      end
      ffha_pkg::OP_RD_R: ra = r_r[AW-1:0];
      ffha_pkg::OP_RD_L: ra = l_r[AW-1:0];
      ffha_pkg::OP_M1: begin
        size_we = 1'b1; size_wa = d_r[AW-1:0]; size_wd = msum_c;
        pn_we   = 1'b1; pn_wa   = d_r[AW-1:0]; pn_wd   = nx_r;
        kind_we = 1'b1; kind_wa = s_r[AW-1:0];
      end
      ffha_pkg::OP_M2: begin
        pp_we = !nx_r[IW-1]; pp_wd = d_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (kind_we) kind_mem[kind_wa] <= kind_wd;
    if (size_we) size_mem[size_wa] <= size_wd;
    if (pp_we)   pp_mem[pp_wa]     <= pp_wd;
    if (pn_we)   pn_mem[pn_wa]     <= pn_wd;
    if (fp_we)   fp_mem[fp_wa]     <= fp_wd;
    if (fn_we)   fn_mem[fn_wa]     <= fn_wd;
    kind_rd_r <= kind_mem[ra];
    size_rd_r <= size_mem[ra];
    pp_rd_r   <= pp_mem[ra];
    pn_rd_r   <= pn_mem[ra];
    fp_rd_r   <= fp_mem[ra];
    fn_rd_r   <= fn_mem[ra];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == ffha_pkg::OP_CLR) clr_cnt_r <= clr_cnt_r + AW'(1);
      unique case (cmd.op)
        ffha_pkg::OP_INIT: head_r <= '0;
        ffha_pkg::OP_S2:   head_r <= r_r;
        ffha_pkg::OP_U1:   if (p_r[IW-1]) head_r <= n_r;
        ffha_pkg::OP_P2:   head_r <= b_r;
        default: ;
      endcase
      if (cmd.out_load)      out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.code;
      out_addr_r   <= cmd.addr_en ? res_addr_r : '0;
    end
    unique case (cmd.op)
      ffha_pkg::OP_ACCEPT: begin
        need_r <= need_c;
        b_r    <= in_ch.req_type ? {1'b0, idx_c} : head_r;
      end
      ffha_pkg::OP_A_RD: begin
        left_r     <= left_c;
        nx_r       <= pn_rd_r;
        p_r        <= fp_rd_r;
        n_r        <= fn_rd_r;
        t_r        <= b_r;
        r_r        <= rcalc_c[IW-1:0];
        res_addr_r <= PW'({b_r[AW-1:0], {ffha_pkg::ALIGN_SH{1'b0}}})
                      + PW'(ffha_pkg::HEADER_BYTES);
        b_r        <= fn_rd_r;
      end
      ffha_pkg::OP_S2: if (head_r == t_r) p_r <= r_r;
      ffha_pkg::OP_F_CHK: begin
        r_r   <= pn_rd_r;
        l_r   <= pp_rd_r;
        szb_r <= size_rd_r;
        cn_r  <= pn_rd_r;
      end
      ffha_pkg::OP_RRD: begin
        nx_r  <= pn_rd_r;
        p_r   <= fp_rd_r;
        n_r   <= fn_rd_r;
        t_r   <= r_r;
        d_r   <= b_r;
        s_r   <= r_r;
        dsz_r <= szb_r;
        ssz_r <= size_rd_r;
      end
      ffha_pkg::OP_M1: begin
        szb_r <= msum_c;
        cn_r  <= nx_r;
      end
      ffha_pkg::OP_LRD: dsz_r <= size_rd_r;
      ffha_pkg::OP_BRD: begin
        p_r   <= fp_rd_r;
        n_r   <= fn_rd_r;
        t_r   <= b_r;
        d_r   <= l_r;
        s_r   <= b_r;
        ssz_r <= szb_r;
        nx_r  <= cn_r;
      end
      default: ;
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.result_addr = out_addr_r;

endmodule
